// File: rtl/arpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the ARP cache resolver: cache geometry,
// result kinds, register indexes and the structs passed along the cell chain.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int CACHE_ENTRIES = 16;
  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  localparam int IP_W   = 32;
  localparam int MAC_W  = 48;
  localparam int TICK_W = 32;
  localparam int LEN_W  = 16;
  localparam int OP_W   = 16;

  localparam int IN_DATA_W  = 176;
  localparam int OUT_DATA_W = 80;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [LEN_W-1:0] MIN_ARP_LEN   = 16'd28;
  localparam logic [OP_W-1:0]  OP_REQUEST    = 16'd1;
  localparam logic [IP_W-1:0]  ALL_ONES_IP   = 32'hFFFF_FFFF;
  localparam logic [MAC_W-1:0] BCAST_MAC     = 48'hFFFF_FFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK = 2'd2;

  typedef enum logic [1:0] {
    KIND_RESOLVED = 2'd0,
    KIND_REQUEST  = 2'd1,
    KIND_REPLY    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // lookup token walking down the cells, one cell per cycle
  typedef struct packed {
    logic              vld;
    logic [IP_W-1:0]   ip;
    logic              match;
    logic [IDX_W-1:0]  match_idx;
    logic [MAC_W-1:0]  match_mac;
    logic              free;
    logic [IDX_W-1:0]  free_idx;
    logic [IDX_W-1:0]  old_idx;
    logic [TICK_W-1:0] old_stamp;
  } scan_t;

  // entry write broadcast to every cell
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [TICK_W-1:0] stamp;
  } wr_t;

endpackage

// File: rtl/arp_cache_resolver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_cache_resolver
// ARP offload cache: learns sender pairs from received packets, orders
// replies to requests for our address and resolves IPs to MACs.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | content
//  in      | in  | in_tvalid/in_tready   | tuser: func; tdata: packet fields
//  out     | out | out_tvalid/out_tready | tuser: kind; tdata: dest_mac,dest_ip
//  cfg     | in  | cfg_we                | own_ip, own_mac, subnet_mask
//
//  a short packet with func 0 is dropped in the cycle it is taken; any other
//  word sends a token down the row of CACHE_ENTRIES cells, one cell per cycle,
//  then, in the done state, writes the entry (func 0 only) and loads any
//  result. reset clears all entry valid bits at once. a full output register
//  stalls a finishing word that has a result until it drains; the next word
//  is taken as soon as the current one has finished.
// ----------------------------------------------------------------------------
module arp_cache_resolver (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: packet_length, opcode, src_ip, src_mac, tgt_ip, now_tick
  input  logic [arpc_pkg::IN_DATA_W-1:0]    in_tdata,
  // tuser: func
  input  logic [0:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: dest_mac, dest_ip
  output logic [arpc_pkg::OUT_DATA_W-1:0]   out_tdata,
  // tuser: kind
  output logic [1:0]                        out_tuser,
  input  logic                              cfg_we,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [arpc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import arpc_pkg::*;

  logic [LEN_W-1:0]  in_len;
  logic [OP_W-1:0]   in_op;
  logic [IP_W-1:0]   in_sip;
  logic [MAC_W-1:0]  in_smac;
  logic [IP_W-1:0]   in_tip;
  logic [TICK_W-1:0] in_tick;

  assign in_len  = in_tdata[15:0];
  assign in_op   = in_tdata[31:16];
  assign in_sip  = in_tdata[63:32];
  assign in_smac = in_tdata[111:64];
  assign in_tip  = in_tdata[143:112];
  assign in_tick = in_tdata[175:144];

  state_t            state_r, state_nxt;
  logic [IP_W-1:0]   own_ip_r;
  logic [IP_W-1:0]   subnet_mask_r;

  logic              func_r;
  logic [OP_W-1:0]   op_r;
  logic [IP_W-1:0]   sip_r;
  logic [MAC_W-1:0]  smac_r;
  logic [IP_W-1:0]   tip_r;
  logic [TICK_W-1:0] tick_r;
  scan_t             res_r;

  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic [MAC_W-1:0]  out_mac_r, out_mac_nxt;
  logic [IP_W-1:0]   out_ip_r, out_ip_nxt;

  logic              accept;
  logic              scan_start;
  logic              out_load;
  logic              res_need;
  kind_t             res_kind;
  logic [MAC_W-1:0]  res_mac;
  logic [IP_W-1:0]   res_ip;
  logic [IP_W-1:0]   host_bits;
  wr_t               wr;
  scan_t             scan_head;
  scan_t             chain [CACHE_ENTRIES+1];

  // own_mac only feeds frame building downstream, so it is not kept here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r      <= '0;
      subnet_mask_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_IP:      own_ip_r      <= cfg_wdata[IP_W-1:0];
        CFG_SUBNET_MASK: subnet_mask_r <= cfg_wdata[IP_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept     = in_tvalid && in_tready;
  assign scan_start = accept && !(!in_tuser[0] && (in_len < MIN_ARP_LEN));

  always_comb begin
    scan_head     = '0;
    scan_head.vld = scan_start;
    scan_head.ip  = in_tuser[0] ? in_tip : in_sip;
  end

  assign chain[0] = scan_head;

  genvar gi;
  generate
    for (gi = 0; gi < CACHE_ENTRIES; gi++) begin : g_cell
      arpc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_idx (IDX_W'(gi)),
        .scan_in  (chain[gi]),
        .scan_out (chain[gi+1]),
        .wr       (wr)
      );
    end
  endgenerate

  assign host_bits = ~subnet_mask_r;

  // result for the finished lookup
  always_comb begin
    res_need = 1'b1;
    res_kind = KIND_RESOLVED;
    res_mac  = BCAST_MAC;
    res_ip   = tip_r;
    if (!func_r) begin
      res_need = (op_r == OP_REQUEST) && (own_ip_r != '0) && (tip_r == own_ip_r);
      res_kind = KIND_REPLY;
      res_mac  = smac_r;
      res_ip   = sip_r;
    end else if ((tip_r == ALL_ONES_IP) || ((tip_r & host_bits) == host_bits)) begin
      res_kind = KIND_RESOLVED;
    end else if (res_r.match) begin
      res_kind = KIND_RESOLVED;
      res_mac  = res_r.match_mac;
    end else begin
      res_kind = KIND_REQUEST;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    out_load      = 1'b0;
    wr            = '0;
    wr.ip         = sip_r;
    wr.mac        = smac_r;
    wr.stamp      = tick_r;
    priority if (res_r.match) begin
      wr.idx = res_r.match_idx;
    end else if (res_r.free) begin
      wr.idx = res_r.free_idx;
    end else begin
      wr.idx = res_r.old_idx;
    end
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (scan_start) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (chain[CACHE_ENTRIES].vld) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold while a result is due and the output register is still full and not draining
        if (!res_need || !out_valid_r || out_tready) begin
          out_load  = res_need;
          wr.en     = !func_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_mac_nxt   = out_mac_r;
    out_ip_nxt    = out_ip_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = res_kind;
      out_mac_nxt   = res_mac;
      out_ip_nxt    = res_ip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_mac_r  <= out_mac_nxt;
    out_ip_r   <= out_ip_nxt;
    if (scan_start) begin
      func_r <= in_tuser[0];
      op_r   <= in_op;
      sip_r  <= in_sip;
      smac_r <= in_smac;
      tip_r  <= in_tip;
      tick_r <= in_tick;
    end
    if (chain[CACHE_ENTRIES].vld) begin
      res_r <= chain[CACHE_ENTRIES];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_ip_r, out_mac_r};
  assign out_tuser  = out_kind_r;

`ifndef SYNTHESIS
  // the token entered at the head of the row leaves the last cell with no stall on the way
  a_scan_latency: assert property (@(posedge clk) disable iff (!rst_n)
    scan_start |-> ##CACHE_ENTRIES chain[CACHE_ENTRIES].vld)
    else $error("lookup token did not leave the cell row on time");

  // no new word is taken while a token leaves the last cell of the row
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !chain[CACHE_ENTRIES].vld)
    else $error("word taken while a lookup is in flight");

  // resolve never changes the cache
  a_resolve_ro: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> !func_r)
    else $error("entry write for a resolve word");

  // a loaded reply carries the reply kind and the sender IP
  a_reply_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !func_r) |=> (out_kind_r == KIND_REPLY) && (out_ip_r == $past(sip_r)))
    else $error("reply result does not match the sender");
`endif

endmodule

// File: rtl/arpc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_cell
// One cache entry. Folds its entry into the passing lookup token (match,
// first free slot, oldest stamp) and registers the token for the next cell.
// ----------------------------------------------------------------------------
module arpc_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [arpc_pkg::IDX_W-1:0] cell_idx,
  input  arpc_pkg::scan_t           scan_in,
  output arpc_pkg::scan_t           scan_out,
  input  arpc_pkg::wr_t             wr
);
  import arpc_pkg::*;

  logic              valid_r;
  logic [IP_W-1:0]   ip_r;
  logic [MAC_W-1:0]  mac_r;
  logic [TICK_W-1:0] stamp_r;
  scan_t             scan_r;
  scan_t             scan_nxt;

  always_comb begin
    scan_nxt = scan_in;
    if (valid_r && (ip_r == scan_in.ip) && !scan_in.match) begin
      scan_nxt.match     = 1'b1;
      scan_nxt.match_idx = cell_idx;
      scan_nxt.match_mac = mac_r;
    end
    if (!valid_r && !scan_in.free) begin
      scan_nxt.free     = 1'b1;
      scan_nxt.free_idx = cell_idx;
    end
    // first cell seeds the oldest search, strict compare keeps lowest index
    if ((cell_idx == '0) || (stamp_r < scan_in.old_stamp)) begin
      scan_nxt.old_idx   = cell_idx;
      scan_nxt.old_stamp = stamp_r;
    end
  end

  // only the valid bits are reset, the data lanes simply follow
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      scan_r.vld <= 1'b0;
    end else begin
      scan_r.vld <= scan_nxt.vld;
      if (wr.en && (wr.idx == cell_idx)) begin
        valid_r <= 1'b1;
      end
    end
    scan_r.ip        <= scan_nxt.ip;
    scan_r.match     <= scan_nxt.match;
    scan_r.match_idx <= scan_nxt.match_idx;
    scan_r.match_mac <= scan_nxt.match_mac;
    scan_r.free      <= scan_nxt.free;
    scan_r.free_idx  <= scan_nxt.free_idx;
    scan_r.old_idx   <= scan_nxt.old_idx;
    scan_r.old_stamp <= scan_nxt.old_stamp;
    if (wr.en && (wr.idx == cell_idx)) begin
      ip_r    <= wr.ip;
      mac_r   <= wr.mac;
      stamp_r <= wr.stamp;
    end
  end

  assign scan_out = scan_r;

endmodule
